// ----- rtl/core/cpss_pkg.sv -----
// ----------------------------------------------------------------------------
// cpss_pkg: shared types, constants and saturation helpers
// Widths, register indexes, sequencer steps and the control struct for the
// cascaded position/speed servo.
// ----------------------------------------------------------------------------
package cpss_pkg;

    // held-value width and fixed-point format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // fixed field widths
    localparam int IO_W      = 32;
    localparam int GAIN_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // adder width covers any three-term sum of held values or port values
    localparam int ALU_W = ((DATA_WIDTH > IO_W) ? DATA_WIDTH : IO_W) + 3;
    localparam int MUL_W = GAIN_W + DATA_WIDTH;

    typedef logic signed [DATA_WIDTH-1:0] dw_t;
    typedef logic signed [ALU_W-1:0]      alu_t;
    typedef logic signed [MUL_W-1:0]      mul_t;
    typedef logic signed [GAIN_W-1:0]     gain_t;
    typedef logic signed [IO_W-1:0]       io_t;
    typedef logic        [LIMIT_W-1:0]    limit_t;

    localparam dw_t DW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam dw_t DW_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_KP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POS_KI    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_POS_KD    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SPD_KP    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPD_KI    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SPD_KD    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPD_LIMIT = CFG_IDX_W'(7);

    // sequencer steps of one loop update
    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_ERR  = 10'b00_0000_0010,
        ST_DP   = 10'b00_0000_0100,
        ST_DD1  = 10'b00_0000_1000,
        ST_DD2  = 10'b00_0001_0000,
        ST_MP   = 10'b00_0010_0000,
        ST_MI   = 10'b00_0100_0000,
        ST_MD   = 10'b00_1000_0000,
        ST_AD   = 10'b01_0000_0000,
        ST_ACC  = 10'b10_0000_0000
    } step_t;

    // sequencer to datapath
    typedef struct packed {
        step_t step;
        logic  loop_pos;
    } ctrl_t;

    // saturate an adder result to the held-value range
    function automatic dw_t sat_alu(input alu_t x);
        alu_t hi;
        alu_t lo;
        hi = alu_t'(DW_MAX);
        lo = alu_t'(DW_MIN);
        if (x > hi)
            return DW_MAX;
        else if (x < lo)
            return DW_MIN;
        else
            return DATA_WIDTH'(x);
    endfunction

    // saturate a scaled product to the held-value range
    function automatic dw_t sat_mul(input mul_t x);
        mul_t hi;
        mul_t lo;
        hi = mul_t'(DW_MAX);
        lo = mul_t'(DW_MIN);
        if (x > hi)
            return DW_MAX;
        else if (x < lo)
            return DW_MIN;
        else
            return DATA_WIDTH'(x);
    endfunction

endpackage

// ----- rtl/core/cpss_mul.sv -----
// ----------------------------------------------------------------------------
// cpss_mul: shared gain multiplier
// Registered signed gain times value product; the output term is the product
// shifted down by the fraction bits (floor) and saturated.
// ----------------------------------------------------------------------------
module cpss_mul
    import cpss_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  gain_t gain,
    input  dw_t   val,
    output dw_t   term
);

    mul_t prod_reg;
    mul_t prod_next;

    // exact product
    assign prod_next = mul_t'(gain) * mul_t'(val);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // floor scaling and saturation
    assign term = sat_mul(prod_reg >>> FRAC_BITS);

endmodule

// ----- rtl/core/cpss_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpss_ctrl: loop update sequencer
// Walks the steps of one incremental PID update, runs the position loop
// first when the item asks for it, then the speed loop.
// ----------------------------------------------------------------------------
module cpss_ctrl
    import cpss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  start_pos,
    input  logic  commit_ok,
    output ctrl_t ctrl
);

    step_t state_reg;
    step_t state_next;
    logic  loop_pos_reg;
    logic  loop_pos_next;

    // next step
    always_comb
    begin
        state_next    = state_reg;
        loop_pos_next = loop_pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next    = ST_ERR;
                    loop_pos_next = start_pos;
                end
            end
            ST_ERR:  state_next = ST_DP;
            ST_DP:   state_next = ST_DD1;
            ST_DD1:  state_next = ST_DD2;
            ST_DD2:  state_next = ST_MP;
            ST_MP:   state_next = ST_MI;
            ST_MI:   state_next = ST_MD;
            ST_MD:   state_next = ST_AD;
            ST_AD:   state_next = ST_ACC;
            ST_ACC:
            begin
                // position loop done: speed loop follows
                if (loop_pos_reg)
                begin
                    state_next    = ST_ERR;
                    loop_pos_next = 1'b0;
                end
                else if (commit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            loop_pos_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            loop_pos_reg <= loop_pos_next;
        end
    end

    assign ctrl.step     = state_reg;
    assign ctrl.loop_pos = loop_pos_reg;

endmodule

// ----- rtl/core/cascaded_position_speed_servo.sv -----
// ----------------------------------------------------------------------------
// cascaded_position_speed_servo: two-loop incremental PID motor servo
// Position loop feeding a speed loop, computed with one shared adder and one
// shared multiplier under a step sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transfer is one servo step. s_tuser[0] selects a
//   position step (1) or a speed step (0). s_tdata carries target, angle and
//   rpm feedback. Output channel m_*: one transfer per step with the clamped
//   drive value and the held position loop output (the speed command).
//   Gains and limits are written through cfg_we/cfg_index/cfg_data while the
//   block is idle; all registers and loop histories reset to zero.
//   Each loop update walks the sequencer steps (error, two differences,
//   three multiplies, three accumulations, clamp), shared adder and
//   multiplier used at most once per step. A speed step runs the speed loop
//   only, a position step the position loop and then the speed loop; a new
//   step is taken only once the sequencer is back in idle.
//   The result sits in an output register. If the receiver stalls, the next
//   step runs up to its last speed-loop step and waits there until the
//   output register is free. Reset (rst_n low) is asynchronous and clears
//   all control, config and loop state.
// ----------------------------------------------------------------------------
module cascaded_position_speed_servo
    import cpss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // target, angle_feedback, rpm_feedback
    input  logic [0:0]           s_tuser,   // action
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // drive_value, speed_command
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_t  ctrl;
    logic   in_xfer;
    logic   out_free;
    logic   commit;
    logic   loop_upd;

    // configuration registers
    gain_t  pos_kp_reg, pos_ki_reg, pos_kd_reg;
    gain_t  spd_kp_reg, spd_ki_reg, spd_kd_reg;
    limit_t pos_limit_reg, spd_limit_reg;

    // loop histories and held outputs
    dw_t    pos_e1_reg, pos_e2_reg, pos_acc_reg;
    dw_t    spd_e1_reg, spd_e2_reg, spd_acc_reg;

    // item and working registers
    logic   act_reg;
    io_t    target_reg, angle_reg, rpm_reg;
    dw_t    e_reg, dp_reg, dd_reg;
    alu_t   tmp_reg;

    // output register
    logic         m_tvalid_reg;
    logic [63:0]  m_tdata_reg;

    // selected loop
    dw_t    e1_cur, e2_cur, acc_cur;
    gain_t  kp_cur, ki_cur, kd_cur;
    limit_t limit_cur;
    alu_t   ref_val, fdb_val;

    // shared units
    alu_t   alu_a, alu_b, alu_sum;
    dw_t    alu_sat;
    alu_t   out_w, lim_w, clamp_w;
    dw_t    out_dw;
    logic   mul_en;
    gain_t  mul_gain;
    dw_t    mul_val;
    dw_t    mul_term;

    // handshakes
    assign s_tready = (ctrl.step == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (ctrl.step == ST_ACC) && !ctrl.loop_pos && out_free;
    assign loop_upd = (ctrl.step == ST_ACC) && (ctrl.loop_pos || out_free);

    cpss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_xfer),
        .start_pos (s_tuser[0]),
        .commit_ok (out_free),
        .ctrl      (ctrl)
    );

    // loop operand selection
    assign e1_cur    = ctrl.loop_pos ? pos_e1_reg    : spd_e1_reg;
    assign e2_cur    = ctrl.loop_pos ? pos_e2_reg    : spd_e2_reg;
    assign acc_cur   = ctrl.loop_pos ? pos_acc_reg   : spd_acc_reg;
    assign kp_cur    = ctrl.loop_pos ? pos_kp_reg    : spd_kp_reg;
    assign ki_cur    = ctrl.loop_pos ? pos_ki_reg    : spd_ki_reg;
    assign kd_cur    = ctrl.loop_pos ? pos_kd_reg    : spd_kd_reg;
    assign limit_cur = ctrl.loop_pos ? pos_limit_reg : spd_limit_reg;

    // speed reference is the held position output in a position step
    assign ref_val = (ctrl.loop_pos || !act_reg) ? alu_t'(target_reg) : alu_t'(pos_acc_reg);
    assign fdb_val = ctrl.loop_pos ? alu_t'(angle_reg) : alu_t'(rpm_reg);

    // shared adder operands
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        unique case (ctrl.step)
            ST_ERR:
            begin
                alu_a = ref_val;
                alu_b = -fdb_val;
            end
            ST_DP:
            begin
                alu_a = alu_t'(e_reg);
                alu_b = -alu_t'(e1_cur);
            end
            ST_DD1:
            begin
                alu_a = alu_t'(e_reg);
                alu_b = -(alu_t'(e1_cur) <<< 1);
            end
            ST_DD2:
            begin
                alu_a = tmp_reg;
                alu_b = alu_t'(e2_cur);
            end
            ST_MI:
            begin
                alu_a = '0;
                alu_b = alu_t'(mul_term);
            end
            ST_MD, ST_AD:
            begin
                alu_a = tmp_reg;
                alu_b = alu_t'(mul_term);
            end
            ST_ACC:
            begin
                alu_a = alu_t'(acc_cur);
                alu_b = alu_t'(sat_alu(tmp_reg));
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + alu_b;
    assign alu_sat = sat_alu(alu_sum);

    // clamp the saturated output to the loop limit
    assign out_w = alu_t'(alu_sat);
    assign lim_w = alu_t'(limit_cur);

    always_comb
    begin
        priority if (out_w > lim_w)
            clamp_w = lim_w;
        else if (out_w < -lim_w)
            clamp_w = -lim_w;
        else
            clamp_w = out_w;
    end

    assign out_dw = DATA_WIDTH'(clamp_w);

    // shared multiplier operands
    always_comb
    begin
        mul_en   = 1'b1;
        mul_gain = '0;
        mul_val  = '0;
        unique case (ctrl.step)
            ST_MP:
            begin
                mul_gain = kp_cur;
                mul_val  = dp_reg;
            end
            ST_MI:
            begin
                mul_gain = ki_cur;
                mul_val  = e_reg;
            end
            ST_MD:
            begin
                mul_gain = kd_cur;
                mul_val  = dd_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    cpss_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .gain (mul_gain),
        .val  (mul_val),
        .term (mul_term)
    );

    // item capture and working values
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg    <= s_tuser[0];
            target_reg <= s_tdata[31:0];
            angle_reg  <= s_tdata[63:32];
            rpm_reg    <= s_tdata[95:64];
        end
        if (ctrl.step == ST_ERR)
            e_reg <= alu_sat;
        if (ctrl.step == ST_DP)
            dp_reg <= alu_sat;
        if (ctrl.step == ST_DD2)
            dd_reg <= alu_sat;
        if (ctrl.step == ST_DD1 || ctrl.step == ST_MI || ctrl.step == ST_MD
            || ctrl.step == ST_AD)
            tmp_reg <= alu_sum;
    end

    // configuration, loop state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_kp_reg    <= '0;
            pos_ki_reg    <= '0;
            pos_kd_reg    <= '0;
            pos_limit_reg <= '0;
            spd_kp_reg    <= '0;
            spd_ki_reg    <= '0;
            spd_kd_reg    <= '0;
            spd_limit_reg <= '0;
            pos_e1_reg    <= '0;
            pos_e2_reg    <= '0;
            pos_acc_reg   <= '0;
            spd_e1_reg    <= '0;
            spd_e2_reg    <= '0;
            spd_acc_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POS_KP:    pos_kp_reg    <= cfg_data;
                    REG_POS_KI:    pos_ki_reg    <= cfg_data;
                    REG_POS_KD:    pos_kd_reg    <= cfg_data;
                    REG_POS_LIMIT: pos_limit_reg <= cfg_data[LIMIT_W-1:0];
                    REG_SPD_KP:    spd_kp_reg    <= cfg_data;
                    REG_SPD_KI:    spd_ki_reg    <= cfg_data;
                    REG_SPD_KD:    spd_kd_reg    <= cfg_data;
                    REG_SPD_LIMIT: spd_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:       pos_kp_reg    <= pos_kp_reg;
                endcase
            end

            // loop write-back: held output and error history
            if (loop_upd)
            begin
                if (ctrl.loop_pos)
                begin
                    pos_acc_reg <= out_dw;
                    pos_e2_reg  <= pos_e1_reg;
                    pos_e1_reg  <= e_reg;
                end
                else
                begin
                    spd_acc_reg <= out_dw;
                    spd_e2_reg  <= spd_e1_reg;
                    spd_e1_reg  <= e_reg;
                end
            end

            // result transfer
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {IO_W'(pos_acc_reg), IO_W'(out_dw)};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a result appears only after the speed loop write-back
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(ctrl.step == ST_ACC && !ctrl.loop_pos))
        else $error("result raised outside speed loop write-back");

    // position loop output stays within its limit after write-back
    a_pos_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step == ST_ACC && ctrl.loop_pos && !cfg_we) |=>
            (alu_t'(pos_acc_reg) <= alu_t'(pos_limit_reg))
            && (alu_t'(pos_acc_reg) >= -alu_t'(pos_limit_reg)))
        else $error("position loop output exceeds its limit");

    // speed loop held output changes only at write-back
    a_spd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(spd_acc_reg) |-> $past(ctrl.step == ST_ACC && !ctrl.loop_pos))
        else $error("speed loop output changed outside write-back");

endmodule

// ----- tb/cascaded_position_speed_servo_test.sv -----
// ----------------------------------------------------------------------------
// cascaded_position_speed_servo_test: self-checking bench for the servo
// Drives position and speed steps over the input stream and checks each
// output transfer against a cycle-free model of the two incremental loops.
// Runs a short table of hand-picked steps, then randomized phases with
// fresh gains and limits, random sender bursts, receiver stalls and
// long receiver hold-offs in some phases.
// ----------------------------------------------------------------------------
module cascaded_position_speed_servo_test;
    import cpss_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int STEP_GOAL       = 1400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_MAX      = 10;
    localparam int LOOP_SPD        = 0;
    localparam int LOOP_POS        = 1;
    localparam int DIR_ROWS        = 24;

    typedef enum bit {
        STEP_SPEED    = 1'b0,
        STEP_POSITION = 1'b1
    } step_kind_t;

    // one hand-picked step; drv/cmd only meaningful when typed is set
    typedef struct packed {
        logic [1:0]  grp;
        step_kind_t  kind;
        logic [31:0] tgt;
        logic [31:0] ang;
        logic [31:0] rpm;
        bit          typed;
        logic [31:0] drv;
        logic [31:0] cmd;
    } servo_row_t;

    // output transfer layout, drive value in the low half
    typedef struct packed {
        logic [31:0] cmd;
        logic [31:0] drive;
    } servo_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;   // target, angle_feedback, rpm_feedback
    logic [0:0]           s_tuser;   // action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;   // drive_value, speed_command
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // model copy of registers and loop history
    longint     cfg_copy [8];
    longint     err_last [2];
    longint     err_prev [2];
    longint     out_acc  [2];
    logic [31:0] next_cfg [8];

    servo_out_t servo_expect_q [$];
    int         mismatch_count;
    int         quiet_cycles;
    int         pos_steps;
    int         spd_steps;
    int         settings_count;
    int         burst_left;
    bit         gaps_on;
    bit         hold_off_req;

    // table of directed steps: reset values, moderate gains, extreme gains
    servo_row_t dir_tab [DIR_ROWS] = '{
        '{2'd0, STEP_POSITION, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h0},
        '{2'd0, STEP_SPEED,    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 32'h0},
        '{2'd0, STEP_POSITION, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0},
        '{2'd0, STEP_SPEED,    32'hFFFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h0},
        '{2'd1, STEP_POSITION, 32'h005A_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_POSITION, 32'h005A_0000, 32'h002D_0000, 32'h0010_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_POSITION, 32'h005A_0000, 32'h0059_0000, 32'h0040_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_SPEED,    32'h03E8_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_SPEED,    32'h03E8_0000, 32'h0000_0000, 32'h0384_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_SPEED,    32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_SPEED,    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_POSITION, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_POSITION, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_POSITION, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_SPEED,    32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
        '{2'd1, STEP_POSITION, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_POSITION, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_POSITION, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_SPEED,    32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_SPEED,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_POSITION, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_SPEED,    32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_POSITION, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{2'd2, STEP_SPEED,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0}
    };

    cascaded_position_speed_servo uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // clip to the signed 32-bit range
    function automatic longint clip_word(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q16.16 gain times value, floor of the scaled product, clipped
    function automatic longint gain_product(input longint g, input longint v);
        longint p;
        p = g * v;
        return clip_word(p >>> 16);
    endfunction

    // one incremental update of a loop, history shifted afterwards
    function automatic void advance_loop(input int lp, input longint kp, input longint ki,
                                         input longint kd, input longint lim,
                                         input longint setpoint, input longint meas);
        longint e;
        longint dp;
        longint dd;
        longint inc;
        longint outv;
        e    = clip_word(setpoint - meas);
        dp   = clip_word(e - err_last[lp]);
        dd   = clip_word(e - 2 * err_last[lp] + err_prev[lp]);
        inc  = clip_word(gain_product(kp, dp) + gain_product(ki, e) + gain_product(kd, dd));
        outv = clip_word(out_acc[lp] + inc);
        if (outv > lim)
            outv = lim;
        if (outv < -lim)
            outv = -lim;
        out_acc[lp]  = outv;
        err_prev[lp] = err_last[lp];
        err_last[lp] = e;
    endfunction

    // servo outputs after one step
    function automatic servo_out_t servo_response(input step_kind_t kind, input logic [31:0] tgt,
                                                  input logic [31:0] ang, input logic [31:0] rpm);
        servo_out_t r;
        if (kind == STEP_POSITION)
        begin
            advance_loop(LOOP_POS, cfg_copy[REG_POS_KP], cfg_copy[REG_POS_KI],
                         cfg_copy[REG_POS_KD], cfg_copy[REG_POS_LIMIT],
                         longint'($signed(tgt)), longint'($signed(ang)));
            advance_loop(LOOP_SPD, cfg_copy[REG_SPD_KP], cfg_copy[REG_SPD_KI],
                         cfg_copy[REG_SPD_KD], cfg_copy[REG_SPD_LIMIT],
                         out_acc[LOOP_POS], longint'($signed(rpm)));
        end
        else
        begin
            advance_loop(LOOP_SPD, cfg_copy[REG_SPD_KP], cfg_copy[REG_SPD_KI],
                         cfg_copy[REG_SPD_KD], cfg_copy[REG_SPD_LIMIT],
                         longint'($signed(tgt)), longint'($signed(rpm)));
        end
        r.drive = 32'(out_acc[LOOP_SPD]);
        r.cmd   = 32'(out_acc[LOOP_POS]);
        return r;
    endfunction

    // boundary words and one random word
    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // offset of up to about +/-1.0 in Q16.16
    function automatic logic [31:0] jitter();
        return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
    endfunction

    function automatic logic [31:0] random_gain();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        else if (pick < 8)
            return corner_word();
        else
            return $urandom();
    endfunction

    function automatic logic [31:0] random_limit();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom();
            default: return 32'($urandom_range(1, 32'h0400_0000));
        endcase
    endfunction

    // write one register, keep the model copy in step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_POS_LIMIT || idx == REG_SPD_LIMIT)
            cfg_copy[idx] = longint'(val[LIMIT_W-1:0]);
        else
            cfg_copy[idx] = longint'($signed(val));
    endtask

    // write all registers from next_cfg
    task automatic apply_settings();
        for (int i = 0; i < 8; i++)
            write_reg(CFG_IDX_W'(i), next_cfg[i]);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_count++;
    endtask

    // wait until every result is back and the block has settled
    task automatic wait_drained();
        while (servo_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // offer one step, record its expected result once transferred
    task automatic send_step(input step_kind_t kind, input logic [31:0] tgt,
                             input logic [31:0] ang, input logic [31:0] rpm,
                             input bit typed, input servo_out_t typed_val);
        servo_out_t want;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rpm, ang, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        want = servo_response(kind, tgt, ang, rpm);
        if (typed)
            want = typed_val;
        servo_expect_q.push_back(want);
        if (kind == STEP_POSITION)
            pos_steps++;
        else
            spd_steps++;
        // sender bursts and gaps
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // random step: mostly plausible closed-loop values, some corners and noise
    task automatic send_random_step();
        step_kind_t  kind;
        logic [31:0] tgt;
        logic [31:0] ang;
        logic [31:0] rpm;
        int          shape;
        servo_out_t  none;
        none  = '0;
        kind  = step_kind_t'($urandom_range(0, 1));
        shape = $urandom_range(0, 9);
        if (shape < 6)
        begin
            tgt = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            ang = tgt + jitter();
            if (kind == STEP_POSITION)
                rpm = 32'(out_acc[LOOP_POS]) + jitter();
            else
                rpm = tgt + jitter();
        end
        else if (shape < 8)
        begin
            tgt = corner_word();
            ang = corner_word();
            rpm = corner_word();
        end
        else
        begin
            tgt = $urandom();
            ang = $urandom();
            rpm = $urandom();
        end
        send_step(kind, tgt, ang, rpm, 1'b0, none);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // output checker
    always @(posedge clk)
    begin
        servo_out_t got;
        servo_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (servo_expect_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", 32'h0, got.drive);
            end
            else
            begin
                want = servo_expect_q.pop_front();
                if (got.drive !== want.drive)
                    report_mismatch("drive_value", want.drive, got.drive);
                if (got.cmd !== want.cmd)
                    report_mismatch("speed_command", want.cmd, got.cmd);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, servo_expect_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: segments of steady, random and toggling ready, plus hold-off
    initial
    begin
        int seg_mode;
        int seg_len;
        m_tready <= 1'b0;
        forever
        begin
            seg_mode = $urandom_range(0, 3);
            seg_len  = $urandom_range(10, 150);
            repeat (seg_len)
            begin
                @(posedge clk);
                if (hold_off_req)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_off_req = 1'b0;
                end
                case (seg_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // main sequence
    initial
    begin
        servo_row_t row;
        servo_out_t typed_val;
        logic [1:0] cur_grp;
        int         phase_idx;
        int         phase_len;
        mismatch_count = 0;
        quiet_cycles   = 0;
        pos_steps      = 0;
        spd_steps      = 0;
        settings_count = 0;
        burst_left     = 0;
        gaps_on        = 1'b0;
        hold_off_req   = 1'b0;
        for (int i = 0; i < 8; i++)
            cfg_copy[i] = 0;
        for (int i = 0; i < 2; i++)
        begin
            err_last[i] = 0;
            err_prev[i] = 0;
            out_acc[i]  = 0;
        end
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; group 0 runs on reset values with zero limits
        cur_grp = 2'd0;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            if (row.grp != cur_grp)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
                cur_grp = row.grp;
                if (cur_grp == 2'd1)
                begin
                    next_cfg[REG_POS_KP]    = 32'h0001_0000;
                    next_cfg[REG_POS_KI]    = 32'h0000_8000;
                    next_cfg[REG_POS_KD]    = 32'h0000_4000;
                    next_cfg[REG_POS_LIMIT] = 32'h0064_0000;
                    next_cfg[REG_SPD_KP]    = 32'h0002_0000;
                    next_cfg[REG_SPD_KI]    = 32'h0000_1000;
                    next_cfg[REG_SPD_KD]    = 32'hFFFF_0000;
                    next_cfg[REG_SPD_LIMIT] = 32'hFFFF_FFFF;
                end
                else
                begin
                    next_cfg[REG_POS_KP]    = 32'h7FFF_FFFF;
                    next_cfg[REG_POS_KI]    = 32'h8000_0000;
                    next_cfg[REG_POS_KD]    = 32'h7FFF_FFFF;
                    next_cfg[REG_POS_LIMIT] = 32'h7FFF_FFFF;
                    next_cfg[REG_SPD_KP]    = 32'h8000_0000;
                    next_cfg[REG_SPD_KI]    = 32'h7FFF_FFFF;
                    next_cfg[REG_SPD_KD]    = 32'h8000_0000;
                    next_cfg[REG_SPD_LIMIT] = 32'h7FFF_FFFF;
                end
                apply_settings();
            end
            typed_val.drive = row.drv;
            typed_val.cmd   = row.cmd;
            send_step(row.kind, row.tgt, row.ang, row.rpm, row.typed, typed_val);
        end

        // random phases, each with its own gains, limits and pacing
        phase_idx = 0;
        while (pos_steps + spd_steps < STEP_GOAL)
        begin
            s_tvalid <= 1'b0;
            wait_drained();
            for (int i = 0; i < 8; i++)
                next_cfg[i] = random_gain();
            next_cfg[REG_POS_LIMIT] = random_limit();
            next_cfg[REG_SPD_LIMIT] = random_limit();
            apply_settings();
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);
            // back-pressure phase: receiver holds off while the sender keeps offering
            if (phase_idx % 5 == 1)
            begin
                gaps_on      = 1'b0;
                hold_off_req = 1'b1;
            end
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) send_random_step();
            phase_idx++;
        end

        // drain and report
        s_tvalid <= 1'b0;
        while (servo_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d position and %0d speed steps under %0d gain/limit settings",
                 pos_steps, spd_steps, settings_count);
        $display("field mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
